// File: design/psl_pkg.sv
// Shared types, sizes and helper functions of the polygon plane slice unit.
package psl_pkg;

	localparam int COORD_BITS    = 32;
	localparam int NORMAL_BITS   = 16;
	localparam int PROD_BITS     = COORD_BITS + NORMAL_BITS;
	localparam int DIST_BITS     = COORD_BITS + NORMAL_BITS + 2;
	localparam int DEN_BITS      = DIST_BITS + 1;
	localparam int QUO_BITS      = COORD_BITS;
	localparam int QCNT_BITS     = $clog2(QUO_BITS);
	localparam int DELTA_BITS    = COORD_BITS + 1;
	localparam int NUM_BITS      = QUO_BITS + DIST_BITS;
	localparam int CHUNK_BITS    = 16;
	localparam int CHUNKS        = (DIST_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
	localparam int CHUNK_IDX     = $clog2(CHUNKS);
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 32;
	localparam int OFS_PAD       = DIST_BITS - COORD_BITS - (NORMAL_BITS - 2);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_NX      = 3'd0,
		CFG_NY      = 3'd1,
		CFG_NZ      = 3'd2,
		CFG_OFFSET  = 3'd3,
		CFG_NORM_EN = 3'd4
	} cfg_idx_t;

	typedef enum logic {
		JOB_POINT = 1'b0,
		JOB_CLOSE = 1'b1
	} job_kind_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0]  pos_x;
		logic signed [COORD_BITS-1:0]  pos_y;
		logic signed [COORD_BITS-1:0]  pos_z;
		logic signed [NORMAL_BITS-1:0] vnorm_x;
		logic signed [NORMAL_BITS-1:0] vnorm_y;
		logic signed [NORMAL_BITS-1:0] vnorm_z;
		logic                          last_vertex;
	} vtx_beat_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0]  start_x;
		logic signed [COORD_BITS-1:0]  start_y;
		logic signed [COORD_BITS-1:0]  start_z;
		logic signed [COORD_BITS-1:0]  end_x;
		logic signed [COORD_BITS-1:0]  end_y;
		logic signed [COORD_BITS-1:0]  end_z;
		logic signed [NORMAL_BITS-1:0] start_nx;
		logic signed [NORMAL_BITS-1:0] start_ny;
		logic signed [NORMAL_BITS-1:0] start_nz;
		logic signed [NORMAL_BITS-1:0] end_nx;
		logic signed [NORMAL_BITS-1:0] end_ny;
		logic signed [NORMAL_BITS-1:0] end_nz;
	} seg_beat_t;

	typedef struct packed {
		logic signed [NORMAL_BITS-1:0] plane_nx;
		logic signed [NORMAL_BITS-1:0] plane_ny;
		logic signed [NORMAL_BITS-1:0] plane_nz;
		logic signed [COORD_BITS-1:0]  plane_offset;
		logic                          normals_enable;
	} plane_cfg_t;

	typedef struct packed {
		logic [2:0][COORD_BITS-1:0]  pos;
		logic [2:0][NORMAL_BITS-1:0] nrm;
		logic signed [DIST_BITS-1:0] dval;
	} vertex_t;

	// One unit of work for the back end: a point found on an edge, or the close of a face.
	typedef struct packed {
		job_kind_t                   kind;
		logic [2:0][COORD_BITS-1:0]  a_pos;
		logic [2:0][NORMAL_BITS-1:0] a_nrm;
		logic [2:0][COORD_BITS-1:0]  b_pos;
		logic [2:0][NORMAL_BITS-1:0] b_nrm;
		logic [DIST_BITS-1:0]        wgt;
		logic [DEN_BITS-1:0]         den;
	} job_t;

	typedef struct packed {
		logic push;
		logic full;
	} q_wr_t;

	function automatic logic [DIST_BITS-1:0] dist_mag(input logic signed [DIST_BITS-1:0] d);
		logic [DIST_BITS-1:0] m;
		m = d[DIST_BITS-1] ? DIST_BITS'(-d) : DIST_BITS'(d);
		return m;
	endfunction

	// True when vertex a gives a point for the edge from a to b.
	function automatic logic edge_hit(input vertex_t a, input vertex_t b);
		logic hit;
		hit = (a.dval == '0)
			|| (a.dval[DIST_BITS-1] && !b.dval[DIST_BITS-1] && b.dval != '0)
			|| (!a.dval[DIST_BITS-1] && a.dval != '0 && b.dval[DIST_BITS-1]);
		return hit;
	endfunction

	// A vertex on the plane is sent with zero weight, which leaves it unchanged.
	function automatic job_t edge_job(input vertex_t a, input vertex_t b);
		job_t j;
		j.kind  = JOB_POINT;
		j.a_pos = a.pos;
		j.a_nrm = a.nrm;
		if (a.dval == '0) begin
			j.b_pos = a.pos;
			j.b_nrm = a.nrm;
			j.wgt   = '0;
			j.den   = DEN_BITS'(1);
		end else begin
			j.b_pos = b.pos;
			j.b_nrm = b.nrm;
			j.wgt   = dist_mag(a.dval);
			j.den   = {1'b0, dist_mag(a.dval)} + {1'b0, dist_mag(b.dval)};
		end
		return j;
	endfunction

endpackage

// File: design/psl_front.sv
// Front end: takes vertices, computes plane distances and queues edge work.
module psl_front import psl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  vtx_beat_t  vtx_in,
	input  plane_cfg_t cfg,
	output q_wr_t      qwr,
	input  logic       q_full,
	output job_t       job
);

	typedef enum logic [4:0] {
		F_IDLE  = 5'b00001,
		F_DIST  = 5'b00010,
		F_EDGE  = 5'b00100,
		F_WRAP  = 5'b01000,
		F_CLOSE = 5'b10000
	} fstate_t;

	fstate_t                     state_q;
	vtx_beat_t                   cur_q;
	logic [1:0]                  mcnt_q;
	logic signed [DIST_BITS-1:0] acc_q;
	logic signed [DIST_BITS-1:0] cur_d_q;
	vertex_t                     first_q;
	vertex_t                     prev_q;
	logic                        in_face_q;

	logic signed [NORMAL_BITS-1:0] nsel;
	logic signed [COORD_BITS-1:0]  psel;
	logic signed [PROD_BITS-1:0]   prod;
	logic signed [DIST_BITS-1:0]   ofs_term;
	vertex_t                       cur_v;
	logic                          hit_edge;
	logic                          hit_wrap;

	assign in_stall = (state_q != F_IDLE);

	always_comb begin
		case (mcnt_q)
			2'd0: begin
				nsel = cfg.plane_nx;
				psel = cur_q.pos_x;
			end
			2'd1: begin
				nsel = cfg.plane_ny;
				psel = cur_q.pos_y;
			end
			default: begin
				nsel = cfg.plane_nz;
				psel = cur_q.pos_z;
			end
		endcase
	end

	assign prod     = {{COORD_BITS{nsel[NORMAL_BITS-1]}}, nsel}
		* {{NORMAL_BITS{psel[COORD_BITS-1]}}, psel};
	assign ofs_term = {{OFS_PAD{cfg.plane_offset[COORD_BITS-1]}}, cfg.plane_offset,
		{(NORMAL_BITS-2){1'b0}}};

	assign cur_v.pos  = {cur_q.pos_z, cur_q.pos_y, cur_q.pos_x};
	assign cur_v.nrm  = {cur_q.vnorm_z, cur_q.vnorm_y, cur_q.vnorm_x};
	assign cur_v.dval = cur_d_q;

	assign hit_edge = in_face_q && edge_hit(prev_q, cur_v);
	assign hit_wrap = edge_hit(cur_v, first_q);

	always_comb begin
		qwr.full = q_full;
		qwr.push = 1'b0;
		job      = edge_job(prev_q, cur_v);
		unique case (state_q)
			F_EDGE: begin
				qwr.push = hit_edge && !q_full;
			end
			F_WRAP: begin
				job      = edge_job(cur_v, first_q);
				qwr.push = hit_wrap && !q_full;
			end
			F_CLOSE: begin
				job.kind = JOB_CLOSE;
				qwr.push = !q_full;
			end
			default: begin
				qwr.push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= F_IDLE;
			mcnt_q    <= '0;
			in_face_q <= 1'b0;
			first_q   <= '0;
			prev_q    <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						state_q <= F_DIST;
						mcnt_q  <= '0;
					end
				end
				F_DIST: begin
					mcnt_q <= mcnt_q + 2'd1;
					if (mcnt_q == 2'd3) begin
						state_q <= F_EDGE;
					end
				end
				F_EDGE: begin
					if (!hit_edge || !q_full) begin
						prev_q <= cur_v;
						if (!in_face_q) begin
							first_q   <= cur_v;
							in_face_q <= 1'b1;
						end
						state_q <= cur_q.last_vertex ? F_WRAP : F_IDLE;
					end
				end
				F_WRAP: begin
					if (!hit_wrap || !q_full) begin
						state_q <= F_CLOSE;
					end
				end
				F_CLOSE: begin
					if (!q_full) begin
						in_face_q <= 1'b0;
						state_q   <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && in_valid) begin
			cur_q <= vtx_in;
			acc_q <= '0;
		end else if (state_q == F_DIST) begin
			if (mcnt_q == 2'd3) begin
				cur_d_q <= acc_q - ofs_term;
			end else begin
				acc_q <= acc_q + {{(DIST_BITS-PROD_BITS){prod[PROD_BITS-1]}}, prod};
			end
		end
	end

endmodule

// File: design/psl_queue.sv
// Short job queue between the front end and the back end.
module psl_queue import psl_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  q_wr_t qwr,
	input  job_t  wr_job,
	input  logic  pop,
	output logic  empty,
	output job_t  head
);

	localparam int DEPTH = 4;
	localparam int PTR_BITS = $clog2(DEPTH);

	job_t                store_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [PTR_BITS:0]   cnt_q;

	assign empty = (cnt_q == '0);
	assign head  = store_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (qwr.push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (PTR_BITS+1)'(qwr.push) - (PTR_BITS+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (qwr.push) begin
			store_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule

// File: design/psl_back.sv
// Back end: interpolates crossing points with a serial divider and emits segments.
module psl_back import psl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_empty,
	input  job_t      q_head,
	output logic      q_pop,
	input  logic      normals_enable,
	output logic      out_valid,
	input  logic      out_stall,
	output seg_beat_t seg_out
);

	typedef enum logic [5:0] {
		B_IDLE  = 6'b000001,
		B_MUL   = 6'b000010,
		B_RND   = 6'b000100,
		B_DIV   = 6'b001000,
		B_STORE = 6'b010000,
		B_KEEP  = 6'b100000
	} bstate_t;

	bstate_t                state_q;
	logic                   emit_q;
	job_t                   job_q;
	logic [2:0]             comp_q;
	logic [CHUNK_IDX-1:0]   chunk_q;
	logic [NUM_BITS-1:0]    num_q;
	logic [DEN_BITS-1:0]    rem_q;
	logic [QCNT_BITS-1:0]   bit_q;
	logic [QUO_BITS-1:0]    quo_q;
	logic [COORD_BITS-1:0]  res_q [6];
	logic [1:0]             cnt_q;
	logic [COORD_BITS-1:0]  kpos_q [2][3];
	logic [NORMAL_BITS-1:0] knrm_q [2][3];
	seg_beat_t              out_q;
	logic                   out_valid_q;

	logic signed [DELTA_BITS-1:0]    a_val;
	logic signed [DELTA_BITS-1:0]    b_val;
	logic signed [DELTA_BITS-1:0]    delta;
	logic [QUO_BITS-1:0]             dmag;
	logic [CHUNKS*CHUNK_BITS-1:0]    wpad;
	logic [CHUNK_BITS-1:0]           wchunk;
	logic [QUO_BITS+CHUNK_BITS-1:0]  part;
	logic [NUM_BITS-1:0]             num_rnd;
	logic [DEN_BITS:0]               rem2;
	logic                            ge;
	logic signed [DELTA_BITS-1:0]    qs;
	logic signed [DELTA_BITS-1:0]    res;
	logic                            out_free;

	always_comb begin
		case (comp_q)
			3'd0: begin
				a_val = {job_q.a_pos[0][COORD_BITS-1], job_q.a_pos[0]};
				b_val = {job_q.b_pos[0][COORD_BITS-1], job_q.b_pos[0]};
			end
			3'd1: begin
				a_val = {job_q.a_pos[1][COORD_BITS-1], job_q.a_pos[1]};
				b_val = {job_q.b_pos[1][COORD_BITS-1], job_q.b_pos[1]};
			end
			3'd2: begin
				a_val = {job_q.a_pos[2][COORD_BITS-1], job_q.a_pos[2]};
				b_val = {job_q.b_pos[2][COORD_BITS-1], job_q.b_pos[2]};
			end
			3'd3: begin
				a_val = {{(DELTA_BITS-NORMAL_BITS){job_q.a_nrm[0][NORMAL_BITS-1]}}, job_q.a_nrm[0]};
				b_val = {{(DELTA_BITS-NORMAL_BITS){job_q.b_nrm[0][NORMAL_BITS-1]}}, job_q.b_nrm[0]};
			end
			3'd4: begin
				a_val = {{(DELTA_BITS-NORMAL_BITS){job_q.a_nrm[1][NORMAL_BITS-1]}}, job_q.a_nrm[1]};
				b_val = {{(DELTA_BITS-NORMAL_BITS){job_q.b_nrm[1][NORMAL_BITS-1]}}, job_q.b_nrm[1]};
			end
			default: begin
				a_val = {{(DELTA_BITS-NORMAL_BITS){job_q.a_nrm[2][NORMAL_BITS-1]}}, job_q.a_nrm[2]};
				b_val = {{(DELTA_BITS-NORMAL_BITS){job_q.b_nrm[2][NORMAL_BITS-1]}}, job_q.b_nrm[2]};
			end
		endcase
	end

	assign delta   = b_val - a_val;
	assign dmag    = delta[DELTA_BITS-1] ? QUO_BITS'(-delta) : QUO_BITS'(delta);
	assign wpad    = {{(CHUNKS*CHUNK_BITS-DIST_BITS){1'b0}}, job_q.wgt};
	assign wchunk  = wpad[(CHUNKS-1-int'(chunk_q))*CHUNK_BITS +: CHUNK_BITS];
	assign part    = {{CHUNK_BITS{1'b0}}, dmag} * {{QUO_BITS{1'b0}}, wchunk};
	assign num_rnd = num_q + NUM_BITS'(job_q.den >> 1);
	assign rem2    = {rem_q, num_q[QUO_BITS-1]};
	assign ge      = (rem2 >= {1'b0, job_q.den});
	assign qs      = delta[DELTA_BITS-1] ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
	assign res     = a_val + qs;

	assign out_free  = !out_valid_q || !out_stall;
	assign q_pop     = (state_q == B_IDLE) && !emit_q && !q_empty;
	assign out_valid = out_valid_q;
	assign seg_out   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			emit_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			comp_q      <= '0;
			chunk_q     <= '0;
			bit_q       <= '0;
		end else begin
			if (out_valid_q && !out_stall && !(state_q == B_IDLE && emit_q)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (emit_q) begin
						if (out_free) begin
							out_valid_q <= 1'b1;
							emit_q      <= 1'b0;
							cnt_q       <= '0;
						end
					end else if (!q_empty) begin
						if (q_head.kind == JOB_CLOSE) begin
							if (cnt_q == 2'd2) begin
								emit_q <= 1'b1;
							end else begin
								cnt_q <= '0;
							end
						end else if (cnt_q != 2'd2) begin
							state_q <= B_MUL;
							comp_q  <= '0;
							chunk_q <= '0;
						end
					end
				end
				B_MUL: begin
					chunk_q <= chunk_q + 1'b1;
					if (chunk_q == CHUNK_IDX'(CHUNKS-1)) begin
						state_q <= B_RND;
					end
				end
				B_RND: begin
					bit_q   <= '0;
					state_q <= B_DIV;
				end
				B_DIV: begin
					bit_q <= bit_q + 1'b1;
					if (bit_q == QCNT_BITS'(QUO_BITS-1)) begin
						state_q <= B_STORE;
					end
				end
				B_STORE: begin
					chunk_q <= '0;
					if (comp_q == 3'd5) begin
						state_q <= B_KEEP;
					end else begin
						comp_q  <= comp_q + 3'd1;
						state_q <= B_MUL;
					end
				end
				B_KEEP: begin
					cnt_q   <= cnt_q + 2'd1;
					state_q <= B_IDLE;
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_head;
			num_q <= '0;
		end
		if (state_q == B_MUL) begin
			num_q <= (num_q << CHUNK_BITS) + NUM_BITS'(part);
		end
		if (state_q == B_RND) begin
			num_q <= num_rnd;
			rem_q <= {1'b0, num_rnd[NUM_BITS-1:QUO_BITS]};
		end
		if (state_q == B_DIV) begin
			num_q <= num_q << 1;
			rem_q <= ge ? DEN_BITS'(rem2 - {1'b0, job_q.den}) : DEN_BITS'(rem2);
			quo_q <= {quo_q[QUO_BITS-2:0], ge};
		end
		if (state_q == B_STORE) begin
			res_q[comp_q] <= COORD_BITS'(res);
			num_q         <= '0;
		end
		if (state_q == B_KEEP) begin
			for (int k = 0; k < 3; k++) begin
				kpos_q[cnt_q[0]][k] <= res_q[k];
				knrm_q[cnt_q[0]][k] <= res_q[k+3][NORMAL_BITS-1:0];
			end
		end
		if (state_q == B_IDLE && emit_q && out_free) begin
			out_q.start_x  <= kpos_q[0][0];
			out_q.start_y  <= kpos_q[0][1];
			out_q.start_z  <= kpos_q[0][2];
			out_q.end_x    <= kpos_q[1][0];
			out_q.end_y    <= kpos_q[1][1];
			out_q.end_z    <= kpos_q[1][2];
			out_q.start_nx <= normals_enable ? knrm_q[0][0] : '0;
			out_q.start_ny <= normals_enable ? knrm_q[0][1] : '0;
			out_q.start_nz <= normals_enable ? knrm_q[0][2] : '0;
			out_q.end_nx   <= normals_enable ? knrm_q[1][0] : '0;
			out_q.end_ny   <= normals_enable ? knrm_q[1][1] : '0;
			out_q.end_nz   <= normals_enable ? knrm_q[1][2] : '0;
		end
	end

endmodule

// File: design/polygon_plane_slice_unit.sv
// Top level of the polygon plane slice unit: configuration, front end, job queue, back end.
//
// Channel   Direction  Handshake              Beat
// vtx_in    in         in_valid / in_stall    one face vertex with its last-vertex mark
// seg_out   out        out_valid / out_stall  one slice segment of a closed face
// cfg       in         cfg_wr_en              one register write, index and data
//
// The front end takes a new vertex only once it is through with the last one: the accept
// cycle, the distance multiply-accumulate and queueing its edge job, which waits while the
// job queue is full. The last vertex of a face also queues its closing edge and the close
// marker. For each point, the back end runs every component through the chunked multiply,
// rounding, and the serial restoring divider that computes one quotient bit per cycle. While
// the back end works on a face, the four-entry queue lets the front end run ahead. Reset
// clears all control state at once.
// A stalled output holds its segment while the back end keeps working on later jobs.
module polygon_plane_slice_unit import psl_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  vtx_beat_t                vtx_in,
	output logic                     out_valid,
	input  logic                     out_stall,
	output seg_beat_t                seg_out,
	input  logic                     cfg_wr_en,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	// Plane registers; the default plane is z = 0 with normals turned off.
	plane_cfg_t cfg_q;

	// Front end to queue and queue to back end.
	q_wr_t qwr;
	logic  q_full;
	job_t  wr_job;
	logic  q_empty;
	logic  q_pop;
	job_t  q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.plane_nx       <= '0;
			cfg_q.plane_ny       <= '0;
			cfg_q.plane_nz       <= NORMAL_BITS'(16384);
			cfg_q.plane_offset   <= '0;
			cfg_q.normals_enable <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_NX:      cfg_q.plane_nx       <= cfg_data[NORMAL_BITS-1:0];
				CFG_NY:      cfg_q.plane_ny       <= cfg_data[NORMAL_BITS-1:0];
				CFG_NZ:      cfg_q.plane_nz       <= cfg_data[NORMAL_BITS-1:0];
				CFG_OFFSET:  cfg_q.plane_offset   <= cfg_data[COORD_BITS-1:0];
				CFG_NORM_EN: cfg_q.normals_enable <= cfg_data[0];
				default: begin
					// Writes to unused indexes are dropped.
				end
			endcase
		end
	end

	psl_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.vtx_in   (vtx_in),
		.cfg      (cfg_q),
		.qwr      (qwr),
		.q_full   (q_full),
		.job      (wr_job)
	);

	// The queue has no full output of its own; the front end only pushes with room.
	psl_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.qwr    (qwr),
		.wr_job (wr_job),
		.pop    (q_pop),
		.empty  (q_empty),
		.head   (q_head)
	);

	// Occupancy is tracked here as well so that the front end sees a full queue.
	logic [2:0] occ_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_q + 3'(qwr.push) - 3'(q_pop);
		end
	end

	assign q_full = (occ_q == 3'd4);

	psl_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_empty),
		.q_head         (q_head),
		.q_pop          (q_pop),
		.normals_enable (cfg_q.normals_enable),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.seg_out        (seg_out)
	);

`ifndef SYNTHESIS
	// The front end never pushes into a full queue.
	assert property (@(posedge clk) disable iff (!arst_n) !(qwr.push && q_full))
		else $error("job pushed into a full queue");

	// The back end never pops an empty queue.
	assert property (@(posedge clk) disable iff (!arst_n) !(q_pop && q_empty))
		else $error("job popped from an empty queue");

	// A vertex is worked on through the distance and edge states, so the front end is busy after accepting.
	assert property (@(posedge clk) disable iff (!arst_n) (in_valid && !in_stall) |=> in_stall)
		else $error("front end ready right after accepting a vertex");
`endif

endmodule
